>>> src/sms_pkg.sv
package sms_pkg;

  localparam int unsigned STEPS_PER_REV_DEF = 2038;
  localparam int unsigned US_PER_MINUTE     = 60000000;
  localparam int unsigned DELAY_W           = 15;
  localparam int unsigned DELAY_MAX         = 32767;
  localparam int unsigned SPEED_W           = 16;
  localparam int unsigned COUNT_W           = 32;
  localparam int unsigned POS_OUT_W         = 11;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_MOVE    = 2'd1,
    OP_DISABLE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic               direction;
    logic [SPEED_W-1:0] speed_rpm;
    logic [COUNT_W-1:0] step_count;
  } sms_in_t;

  typedef struct packed {
    logic                 coil_one;
    logic                 coil_two;
    logic                 driver_enable;
    logic [POS_OUT_W-1:0] position;
    logic                 busy_res;
    logic                 rejected;
  } sms_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sms_div_sts_t;

  // phase -> {coil_two, coil_one}
  function automatic logic [1:0] phase_coils(logic [1:0] phase);
    logic [1:0] c;
    case (phase)
      2'd0:    c = 2'b10;
      2'd1:    c = 2'b11;
      2'd2:    c = 2'b01;
      default: c = 2'b00;
    endcase
    return c;
  endfunction

endpackage

>>> src/sms_stream_if.sv
interface sms_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/sms_div.sv
// Restoring divider: constant (60e6 / STEPS_PER_REV) over the speed, one
// quotient bit per cycle, result saturated to the delay width.
module sms_div #(
  parameter int unsigned STEPS_PER_REV = sms_pkg::STEPS_PER_REV_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sms_pkg::SPEED_W-1:0]  divisor_i,
  output sms_pkg::sms_div_sts_t        sts_o,
  output logic [sms_pkg::DELAY_W-1:0]  delay_o
);
  import sms_pkg::*;

  localparam int unsigned NUM   = US_PER_MINUTE / STEPS_PER_REV;
  localparam int unsigned NUM_W = $clog2(NUM + 1);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam int unsigned QW    = (NUM_W > DELAY_W) ? NUM_W : DELAY_W;

  logic [SPEED_W-1:0] rem_q, rem_d;
  logic [SPEED_W-1:0] div_q, div_d;
  logic [NUM_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [SPEED_W:0]   trial;
  logic [SPEED_W:0]   diff;
  logic               ge;
  logic [QW-1:0]      quo_ext;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = NUM_W'(NUM);
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign quo_ext = QW'(quo_q);
  assign delay_o = (quo_ext > QW'(DELAY_MAX)) ? DELAY_W'(DELAY_MAX) : quo_ext[DELAY_W-1:0];
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");

endmodule

>>> src/stepper_move_sequencer_top.sv
// Channel  Dir  Payload                                         Handshake
// in_i     in   operation, direction, speed_rpm, step_count     valid/ready
// out_o    out  coil_one, coil_two, driver_enable, position,    valid/ready
//               busy_res, rejected
//
// Tick, disable, unused code, refused and zero-count move: result registered
// in the cycle after the request, next request taken in the same cycle the
// result leaves. A started move runs the divider, one bit per cycle, on a
// quotient of NUM_W bits, NUM_W = bits of 60e6/STEPS_PER_REV (15 at 2038).
// Reset clears all motion state; the driver sleeps, coils low.
// in_i.ready drops in ST_DIV and ST_FIN and while a result stalls on out_o.
module stepper_move_sequencer_top #(
  parameter int unsigned STEPS_PER_REV = sms_pkg::STEPS_PER_REV_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sms_stream_if.sink   in_i,
  sms_stream_if.source out_o
);
  import sms_pkg::*;

  localparam int unsigned POS_W     = $clog2(STEPS_PER_REV);
  localparam int unsigned POS_EXT_W = (POS_W > POS_OUT_W) ? POS_W : POS_OUT_W;

  state_e state_q, state_d;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [COUNT_W-1:0] left_q, left_d;
  logic [DELAY_W-1:0] reload_q, reload_d;
  logic [DELAY_W-1:0] dly_q, dly_d;
  logic               moving_q, moving_d;
  logic               dir_q, dir_d;
  logic               en_q, en_d;
  logic [1:0]         coil_q, coil_d;
  logic               out_valid_q, out_valid_d;
  sms_out_t           out_data_q, out_data_d;

  sms_in_t            req;
  logic               accept;
  logic               out_free;
  logic               move_ok;
  logic               div_start;
  logic               fin_fire;
  logic               step_en;
  logic               write_out;
  logic               rej;
  logic [POS_W:0]     pos_inc;
  logic [POS_W-1:0]   pos_step;
  logic [DELAY_W-1:0] dly_dec;
  logic [POS_EXT_W-1:0] pos_ext;
  sms_div_sts_t       div_sts;
  logic [DELAY_W-1:0] div_delay;

  assign req      = in_i.data;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept   = in_i.valid && in_i.ready;
  assign move_ok  = (req.operation == OP_MOVE) && (req.speed_rpm != '0) && !moving_q
                    && (req.step_count != '0);

  sms_div #(.STEPS_PER_REV(STEPS_PER_REV)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (req.speed_rpm),
    .sts_o     (div_sts),
    .delay_o   (div_delay)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && move_ok) state_d = ST_DIV;
      ST_DIV:  if (div_sts.done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_start = 1'b0;
    fin_fire  = 1'b0;
    unique case (state_q)
      ST_IDLE: div_start = accept && move_ok;
      ST_DIV:  ;
      ST_FIN:  fin_fire = out_free;
      default: ;
    endcase
  end

  assign pos_inc  = {1'b0, pos_q} + 1'b1;
  assign dly_dec  = (dly_q != '0) ? dly_q - 1'b1 : dly_q;

  always_comb begin
    if (dir_q) begin
      pos_step = (pos_inc >= (POS_W+1)'(STEPS_PER_REV)) ? '0 : pos_inc[POS_W-1:0];
    end else begin
      pos_step = (pos_q == '0) ? POS_W'(STEPS_PER_REV - 1) : pos_q - 1'b1;
    end
  end

  always_comb begin
    pos_d     = pos_q;
    left_d    = left_q;
    reload_d  = reload_q;
    dly_d     = dly_q;
    moving_d  = moving_q;
    dir_d     = dir_q;
    en_d      = en_q;
    coil_d    = coil_q;
    step_en   = 1'b0;
    write_out = 1'b0;
    rej       = 1'b0;

    if (accept) begin
      unique case (req.operation)
        OP_TICK: begin
          write_out = 1'b1;
          if (moving_q) begin
            dly_d = dly_dec;
            if (dly_dec == '0) begin
              if (left_q != '0) step_en = 1'b1;
              else moving_d = 1'b0;
            end
          end
        end
        OP_MOVE: begin
          if (req.speed_rpm == '0 || moving_q) begin
            rej       = 1'b1;
            write_out = 1'b1;
          end else if (req.step_count == '0) begin
            en_d      = 1'b1;
            write_out = 1'b1;
          end else begin
            // result follows once the divider is done
            dir_d  = req.direction;
            left_d = req.step_count;
          end
        end
        OP_DISABLE: begin
          en_d      = 1'b0;
          write_out = 1'b1;
        end
        default: write_out = 1'b1;
      endcase
    end

    if (fin_fire) begin
      reload_d  = div_delay;
      en_d      = 1'b1;
      moving_d  = 1'b1;
      step_en   = 1'b1;
      write_out = 1'b1;
    end

    if (step_en) begin
      pos_d  = pos_step;
      left_d = left_q - 1'b1;
      coil_d = phase_coils(pos_step[1:0]);
      dly_d  = reload_d;
    end
  end

  assign pos_ext = POS_EXT_W'(pos_d);

  always_comb begin
    out_data_d.coil_one      = coil_d[0];
    out_data_d.coil_two      = coil_d[1];
    out_data_d.driver_enable = en_d;
    out_data_d.position      = pos_ext[POS_OUT_W-1:0];
    out_data_d.busy_res      = moving_d;
    out_data_d.rejected      = rej;
    if (write_out) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      left_q      <= '0;
      reload_q    <= '0;
      dly_q       <= '0;
      moving_q    <= 1'b0;
      dir_q       <= 1'b0;
      en_q        <= 1'b0;
      coil_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      left_q      <= left_d;
      reload_q    <= reload_d;
      dly_q       <= dly_d;
      moving_q    <= moving_d;
      dir_q       <= dir_d;
      en_q        <= en_d;
      coil_q      <= coil_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_out) out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(STEPS_PER_REV - 1) || pos_q == POS_W'(STEPS_PER_REV - 1))
    else $error("step position out of range");
  a_idle_no_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !moving_q) |-> left_q == '0)
    else $error("steps pending while idle");
  a_div_not_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (!moving_q && !in_i.ready))
    else $error("division overlaps a move");
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> state_q == ST_DIV)
    else $error("divider result outside division");

endmodule

>>> sim/tb_stepper_move_sequencer_top.sv
module tb_stepper_move_sequencer_top;
  import sms_pkg::*;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned TAIL_CYCLES  = 40;

  // Mirrors the sequencer state; one expected result per accepted request.
  class step_scoreboard;
    int unsigned        pos;
    logic [31:0]        steps_left;
    logic [DELAY_W-1:0] reload;
    logic [DELAY_W-1:0] delay_left;
    bit                 moving;
    bit                 forward;
    bit                 awake;
    logic [1:0]         coils;  // {coil_two, coil_one}
    sms_out_t           expected_q[$];
    int unsigned        errors, checked, started, refused;

    function new();
      pos        = 0;
      steps_left = '0;
      reload     = '0;
      delay_left = '0;
      coils      = 2'b00;
    endfunction

    static function int unsigned delay_ticks(logic [SPEED_W-1:0] spd);
      int unsigned d;
      d = (US_PER_MINUTE / STEPS_PER_REV_DEF) / spd;
      if (d > DELAY_MAX) d = DELAY_MAX;
      return d;
    endfunction

    function void take_step();
      if (forward) begin
        pos = (pos + 1 >= STEPS_PER_REV_DEF) ? 0 : pos + 1;
      end else begin
        if (pos == 0 || pos > STEPS_PER_REV_DEF) pos = STEPS_PER_REV_DEF;
        pos = pos - 1;
      end
      steps_left = steps_left - 1;
      case (pos % 4)
        0:       coils = 2'b10;
        1:       coils = 2'b11;
        2:       coils = 2'b01;
        default: coils = 2'b00;
      endcase
      delay_left = reload;
    endfunction

    function void note_request(sms_in_t r);
      sms_out_t e;
      bit       rej;
      rej = 0;
      case (r.operation)
        OP_TICK: begin
          if (moving) begin
            if (delay_left != 0) delay_left = delay_left - 1;
            if (delay_left == 0) begin
              if (steps_left != 0) take_step();
              else moving = 0;
            end
          end
        end
        OP_MOVE: begin
          if (r.speed_rpm == 0 || moving) begin
            rej = 1;
            refused++;
          end else begin
            reload     = DELAY_W'(delay_ticks(r.speed_rpm));
            forward    = r.direction;
            awake      = 1;
            steps_left = r.step_count;
            started++;
            if (r.step_count != 0) begin
              moving = 1;
              take_step();
            end
          end
        end
        OP_DISABLE: awake = 0;
        default: ;
      endcase
      e.coil_one      = coils[0];
      e.coil_two      = coils[1];
      e.driver_enable = awake;
      e.position      = pos[POS_OUT_W-1:0];
      e.busy_res      = moving;
      e.rejected      = rej;
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    task check_result(sms_out_t got);
      sms_out_t e;
      if (expected_q.size() == 0) begin
        report("result with no request pending");
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (got.coil_one !== e.coil_one)
          report($sformatf("coil_one %0b, want %0b", got.coil_one, e.coil_one));
        if (got.coil_two !== e.coil_two)
          report($sformatf("coil_two %0b, want %0b", got.coil_two, e.coil_two));
        if (got.driver_enable !== e.driver_enable)
          report($sformatf("driver_enable %0b, want %0b", got.driver_enable,
                           e.driver_enable));
        if (got.position !== e.position)
          report($sformatf("position %0d, want %0d", got.position, e.position));
        if (got.busy_res !== e.busy_res)
          report($sformatf("busy_res %0b, want %0b", got.busy_res, e.busy_res));
        if (got.rejected !== e.rejected)
          report($sformatf("rejected %0b, want %0b", got.rejected, e.rejected));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  sms_stream_if #(.T(sms_in_t))  in_if ();
  sms_stream_if #(.T(sms_out_t)) out_if ();

  stepper_move_sequencer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  step_scoreboard sb = new();
  int unsigned    gap_pct;
  int unsigned    stall_pct;
  int unsigned    n_sent;
  int unsigned    cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    gap_pct      = 0;
    stall_pct    = 0;
    n_sent       = 0;
    cycles       = 0;
  end

  always @(posedge clk_i) out_if.ready <= ($urandom_range(99, 0) >= stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_request(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               sb.expected_q.size());
      $display("tb_stepper_move_sequencer_top: done, errors");
      $finish;
    end
  end

  function automatic sms_in_t mk_req(logic [1:0] op, logic dir, logic [15:0] spd,
                                     logic [31:0] cnt);
    sms_in_t r;
    r.operation  = op;
    r.direction  = dir;
    r.speed_rpm  = spd;
    r.step_count = cnt;
    return r;
  endfunction

  function automatic sms_in_t mk_rand(logic [1:0] op);
    return mk_req(op, 1'($urandom_range(1, 0)), 16'($urandom), $urandom);
  endfunction

  // valid stays high after acceptance; the next send or a drain moves it
  task automatic send(sms_in_t r);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= r;
    do @(posedge clk_i); while (!in_if.ready);
    if (r.operation != OP_UNUSED) n_sent++;
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send(mk_rand(OP_TICK));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  // One move run to idle, with disables, refused moves and stray codes mixed in.
  task automatic run_move();
    logic [15:0] spd;
    logic [31:0] cnt;
    int unsigned d, busy_ticks, pick;
    pick = $urandom_range(99, 0);
    if (pick < 70)      spd = 16'($urandom_range(65535, 14720));
    else if (pick < 95) spd = 16'($urandom_range(14719, 1000));
    else                spd = 16'($urandom_range(999, 100));
    d   = step_scoreboard::delay_ticks(spd);
    cnt = (d > 29) ? $urandom_range(2, 1) : $urandom_range(8, 0);
    send(mk_req(OP_MOVE, 1'($urandom_range(1, 0)), spd, cnt));
    // each step, and the closing wait, lasts max(delay, 1) ticks
    busy_ticks = cnt * ((d == 0) ? 1 : d);
    for (int i = 0; i < busy_ticks + $urandom_range(2, 0); i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 4)                       send(mk_rand(OP_DISABLE));
      else if (pick < 8 && i < busy_ticks) send(mk_rand(OP_MOVE));
      else if (pick < 9)                  send(mk_rand(OP_UNUSED));
      send(mk_rand(OP_TICK));
    end
  endtask

  // Idle-state noise; moves here either have zero speed or zero count.
  task automatic run_noise();
    logic [1:0] op;
    sms_in_t    r;
    repeat ($urandom_range(4, 1)) begin
      op = 2'($urandom_range(3, 0));
      r  = mk_rand(op);
      if (op == OP_MOVE) begin
        if ($urandom_range(1, 0)) r.speed_rpm = '0;
        else r.step_count = '0;
      end
      send(r);
    end
  endtask

  task automatic run_random(int unsigned upto);
    while (n_sent < upto) begin
      if ($urandom_range(99, 0) < 85) run_move();
      else run_noise();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct   = 15;
    stall_pct = 51;

    // idle behavior, refusals, zero count, wrap both ways, disable mid-move
    send(mk_rand(OP_TICK));
    send(mk_rand(OP_DISABLE));
    send(mk_req(OP_UNUSED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
    send(mk_req(OP_MOVE, 1'b1, 16'd0, 32'd5));
    send(mk_req(OP_MOVE, 1'b1, 16'd1, 32'd0));
    send(mk_req(OP_MOVE, 1'b0, 16'hFFFF, 32'd3));
    send(mk_req(OP_MOVE, 1'b1, 16'd40000, 32'd7));
    send(mk_req(OP_DISABLE, 1'b0, 16'd0, 32'd0));
    send_ticks(3);
    send(mk_rand(OP_TICK));
    send(mk_req(OP_MOVE, 1'b1, 16'hFFFF, 32'd3));
    send_ticks(3);
    send(mk_req(OP_MOVE, 1'b1, 16'd14720, 32'd2));
    send_ticks(4);
    drain();

    run_random(500);
    drain();

    gap_pct   = 51;
    stall_pct = 15;
    run_random(1000);
    drain();

    gap_pct   = 0;
    stall_pct = 0;
    run_random(1500);

    // endless move last: nothing can end it short of reset
    drain();
    send(mk_req(OP_MOVE, 1'($urandom_range(1, 0)), 16'hFFFF, 32'hFFFF_FFFF));
    send_ticks(20);
    send(mk_req(OP_MOVE, 1'b1, 16'd1, 32'd1));
    send(mk_rand(OP_DISABLE));
    send_ticks(5);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    $display("%0d requests sent, %0d results checked in %0d cycles", n_sent,
             sb.checked, cycles);
    $display("moves started %0d, refused %0d; three idle/stall mixes", sb.started,
             sb.refused);
    if (sb.errors == 0) begin
      $display("tb_stepper_move_sequencer_top: done, clean");
    end else begin
      $display("tb_stepper_move_sequencer_top: done, errors");
    end
    $finish;
  end

endmodule
